FILE: hdl/mfc_pkg.sv
`timescale 1ns / 1ps

package mfc_pkg;

    localparam logic [15:0] EVT_SYNC   = 16'h0000;
    localparam logic [15:0] EVT_ABS    = 16'h0003;

    localparam logic [15:0] CODE_SLOT  = 16'h002F;
    localparam logic [15:0] CODE_TRACK = 16'h0039;
    localparam logic [15:0] CODE_X     = 16'h0035;
    localparam logic [15:0] CODE_Y     = 16'h0036;

    localparam logic [31:0] LIFT_ID    = 32'hFFFF_FFFF;

    localparam logic [1:0]  KIND_TOUCH   = 2'd0;
    localparam logic [1:0]  KIND_UNTOUCH = 2'd1;
    localparam logic [1:0]  KIND_CLEAR   = 2'd2;

    typedef struct packed {
        logic [15:0]        event_type;
        logic [15:0]        event_code;
        logic signed [31:0] event_value;
    } event_word_t;

    typedef struct packed {
        logic valid;
        logic take;
    } word_hs_t;

endpackage

FILE: hdl/multitouch_finger_classifier.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Word
// event     in         event_valid / event_stall   event_type, event_code, event_value
// touch     out        touch_valid / touch_stall   touch_kind, touch_x, touch_y
// config    in         cfg_write                   cfg_data (remote connected)
//
// One event word is taken every cycle unless stalled; sync results are registered.
// The rate is set by the single state update between the input and result registers.
// Reset clears the tracking state and remote connected; no clearing pass is needed.
// A stalled result holds the tracker, and the input register then stalls the event side.

module multitouch_finger_classifier (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               event_valid,
    output logic               event_stall,
    input  logic [15:0]        event_type,
    input  logic [15:0]        event_code,
    input  logic signed [31:0] event_value,
    output logic               touch_valid,
    input  logic               touch_stall,
    output logic [1:0]         touch_kind,
    output logic signed [31:0] touch_x,
    output logic signed [31:0] touch_y
);

    mfc_pkg::event_word_t word;
    mfc_pkg::word_hs_t    hs;
    logic                 word_take;

    mfc_input_reg u_input_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .word        (word),
        .word_take   (word_take),
        .hs          (hs)
    );

    mfc_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .word        (word),
        .word_valid  (hs.valid),
        .word_take   (word_take),
        .touch_valid (touch_valid),
        .touch_stall (touch_stall),
        .touch_kind  (touch_kind),
        .touch_x     (touch_x),
        .touch_y     (touch_y)
    );

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        touch_valid && (touch_kind == mfc_pkg::KIND_CLEAR)
        |-> (touch_x == 32'd0) && (touch_y == 32'd0))
        else $error("clear result carries non-zero coordinates");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        touch_valid |-> (touch_kind == mfc_pkg::KIND_TOUCH) || (touch_kind == mfc_pkg::KIND_UNTOUCH)
                        || (touch_kind == mfc_pkg::KIND_CLEAR))
        else $error("result kind out of range");

    a_take_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        hs.take |-> hs.valid)
        else $error("tracker took a word the input register does not hold");

    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        hs.valid && touch_valid && touch_stall |-> event_stall)
        else $error("event side not stalled while the result is blocked");

endmodule

FILE: hdl/mfc_input_reg.sv
`timescale 1ns / 1ps

module mfc_input_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                event_valid,
    output logic                event_stall,
    input  logic [15:0]         event_type,
    input  logic [15:0]         event_code,
    input  logic signed [31:0]  event_value,
    output mfc_pkg::event_word_t word,
    input  logic                word_take,
    output mfc_pkg::word_hs_t   hs
);

    logic                 held_reg;
    logic                 held_next;
    mfc_pkg::event_word_t word_reg;
    logic                 accept;

    // The holding register may be refilled in the same cycle that its word moves on.
    assign event_stall = held_reg && !word_take;
    assign accept      = event_valid && !event_stall;

    always_comb
    begin
        if (accept)
        begin
            held_next = 1'b1;
        end
        else if (word_take)
        begin
            held_next = 1'b0;
        end
        else
        begin
            held_next = held_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.event_type  <= event_type;
            word_reg.event_code  <= event_code;
            word_reg.event_value <= event_value;
        end
    end

    assign word    = word_reg;
    assign hs.valid = held_reg;
    assign hs.take  = word_take;

endmodule

FILE: hdl/mfc_tracker.sv
`timescale 1ns / 1ps

module mfc_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic                 cfg_data,
    input  mfc_pkg::event_word_t word,
    input  logic                 word_valid,
    output logic                 word_take,
    output logic                 touch_valid,
    input  logic                 touch_stall,
    output logic [1:0]           touch_kind,
    output logic signed [31:0]   touch_x,
    output logic signed [31:0]   touch_y
);

    typedef enum logic [1:0] {
        PFX_START = 2'd0,
        PFX_SLOT0 = 2'd1,
        PFX_MATCH = 2'd2,
        PFX_NONE  = 2'd3
    } prefix_t;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_ONE   = 2'd1,
        CLS_MULTI = 2'd2
    } class_t;

    logic          remote_reg;
    prefix_t       prefix_reg,   prefix_next;
    logic          finger_reg,   finger_next;
    class_t        class_reg,    class_next;
    class_t        reported_reg, reported_next;
    logic [31:0]   primary_reg,  primary_next;
    logic [31:0]   slot_reg,     slot_next;
    logic [31:0]   track_reg,    track_next;
    logic [31:0]   x_reg,        x_next;
    logic [31:0]   y_reg,        y_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    kind_reg,     kind_next;
    logic [31:0]   ox_reg,       ox_next;
    logic [31:0]   oy_reg,       oy_next;

    logic          is_abs;
    logic          is_lift;
    logic          is_slot0;
    logic          is_pos;
    logic [31:0]   value;
    logic          emit;

    assign word_take = word_valid && (!out_valid_reg || !touch_stall);
    assign value     = word.event_value;
    assign is_abs    = (word.event_type == mfc_pkg::EVT_ABS);
    assign is_lift   = is_abs && (word.event_code == mfc_pkg::CODE_TRACK)
                       && (value == mfc_pkg::LIFT_ID);
    assign is_slot0  = is_abs && (word.event_code == mfc_pkg::CODE_SLOT) && (value == 32'd0);
    assign is_pos    = is_abs && ((word.event_code == mfc_pkg::CODE_X)
                       || (word.event_code == mfc_pkg::CODE_Y))
                       && (track_reg != mfc_pkg::LIFT_ID);

    always_comb
    begin
        prefix_next   = prefix_reg;
        finger_next   = finger_reg;
        class_next    = class_reg;
        reported_next = reported_reg;
        primary_next  = primary_reg;
        slot_next     = slot_reg;
        track_next    = track_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        kind_next     = kind_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        emit          = 1'b0;

        if (word.event_type != mfc_pkg::EVT_SYNC)
        begin
            unique case (prefix_reg)
                PFX_START:
                begin
                    prefix_next = is_lift ? PFX_MATCH : (is_slot0 ? PFX_SLOT0 : PFX_NONE);
                end
                PFX_SLOT0:
                begin
                    prefix_next = is_lift ? PFX_MATCH : PFX_NONE;
                end
                PFX_MATCH, PFX_NONE:
                begin
                    prefix_next = prefix_reg;
                end
            endcase

            if (is_abs && (word.event_code == mfc_pkg::CODE_SLOT))
            begin
                slot_next = value;
            end
            if (is_abs && (word.event_code == mfc_pkg::CODE_TRACK))
            begin
                track_next = value;
            end
            if (is_pos)
            begin
                if (!finger_reg)
                begin
                    finger_next  = 1'b1;
                    class_next   = CLS_ONE;
                    primary_next = slot_reg;
                end
                else if (primary_reg != slot_reg)
                begin
                    class_next = CLS_MULTI;
                end
                if (word.event_code == mfc_pkg::CODE_X)
                begin
                    x_next = value;
                end
                else
                begin
                    y_next = value;
                end
            end
        end
        else
        begin
            slot_next   = 32'd0;
            track_next  = 32'd0;
            prefix_next = PFX_START;
            if (prefix_reg == PFX_MATCH)
            begin
                class_next  = CLS_NONE;
                finger_next = 1'b0;
            end
            if (class_next != reported_reg)
            begin
                reported_next = class_next;
                emit          = !remote_reg;
                if (class_next == CLS_ONE)
                begin
                    kind_next = mfc_pkg::KIND_TOUCH;
                    ox_next   = x_reg;
                    oy_next   = y_reg;
                end
                else if ((class_next == CLS_NONE) && (reported_reg == CLS_ONE))
                begin
                    kind_next = mfc_pkg::KIND_UNTOUCH;
                    ox_next   = x_reg;
                    oy_next   = y_reg;
                end
                else
                begin
                    kind_next = mfc_pkg::KIND_CLEAR;
                    ox_next   = 32'd0;
                    oy_next   = 32'd0;
                end
            end
        end
    end

    always_comb
    begin
        if (word_take)
        begin
            out_valid_next = emit;
        end
        else if (!touch_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remote_reg    <= 1'b0;
            prefix_reg    <= PFX_START;
            finger_reg    <= 1'b0;
            class_reg     <= CLS_NONE;
            reported_reg  <= CLS_NONE;
            primary_reg   <= 32'd0;
            slot_reg      <= 32'd0;
            track_reg     <= 32'd0;
            x_reg         <= 32'd0;
            y_reg         <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                remote_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
            if (word_take)
            begin
                prefix_reg   <= prefix_next;
                finger_reg   <= finger_next;
                class_reg    <= class_next;
                reported_reg <= reported_next;
                primary_reg  <= primary_next;
                slot_reg     <= slot_next;
                track_reg    <= track_next;
                x_reg        <= x_next;
                y_reg        <= y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_take && emit)
        begin
            kind_reg <= kind_next;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
        end
    end

    assign touch_valid = out_valid_reg;
    assign touch_kind  = kind_reg;
    assign touch_x     = ox_reg;
    assign touch_y     = oy_reg;

endmodule

FILE: test/touch_result_checker.sv
`timescale 1ns / 1ps

module touch_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               event_valid,
    input  logic               event_stall,
    input  logic [15:0]        event_type,
    input  logic [15:0]        event_code,
    input  logic signed [31:0] event_value,
    input  logic               touch_valid,
    input  logic               touch_stall,
    input  logic [1:0]         touch_kind,
    input  logic signed [31:0] touch_x,
    input  logic signed [31:0] touch_y,
    output int                 failures,
    output int                 outstanding
);

    typedef enum logic [1:0] {PFX_START, PFX_SLOT0, PFX_MATCH, PFX_NONE} prefix_t;
    typedef enum logic [1:0] {CLASS_NONE, CLASS_ONE, CLASS_MULTI} finger_class_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } touch_word_t;

    touch_word_t   expected_touches[$];

    logic          remote;
    prefix_t       prefix;
    logic          present;
    finger_class_t cls;
    finger_class_t reported;
    logic [31:0]   primary;
    logic [31:0]   sel_slot;
    logic [31:0]   track_id;
    logic [31:0]   last_x;
    logic [31:0]   last_y;

    function automatic void place_finger(logic is_x, logic [31:0] value);
        if (track_id == mfc_pkg::LIFT_ID)
        begin
            return;
        end
        if (!present)
        begin
            present = 1'b1;
            cls     = CLASS_ONE;
            primary = sel_slot;
        end
        else if (primary != sel_slot)
        begin
            cls = CLASS_MULTI;
        end
        if (is_x)
        begin
            last_x = value;
        end
        else
        begin
            last_y = value;
        end
    endfunction

    function automatic void classify_event(logic [15:0] etype, logic [15:0] ecode,
                                           logic [31:0] evalue);
        logic        is_abs;
        logic        lift;
        logic        slot0;
        touch_word_t word;
        if (etype != mfc_pkg::EVT_SYNC)
        begin
            is_abs = (etype == mfc_pkg::EVT_ABS);
            lift   = is_abs && ecode == mfc_pkg::CODE_TRACK && evalue == mfc_pkg::LIFT_ID;
            slot0  = is_abs && ecode == mfc_pkg::CODE_SLOT && evalue == 32'd0;
            if (prefix == PFX_START)
            begin
                prefix = lift ? PFX_MATCH : (slot0 ? PFX_SLOT0 : PFX_NONE);
            end
            else if (prefix == PFX_SLOT0)
            begin
                prefix = lift ? PFX_MATCH : PFX_NONE;
            end
            if (is_abs)
            begin
                unique case (ecode)
                    mfc_pkg::CODE_SLOT:  sel_slot = evalue;
                    mfc_pkg::CODE_TRACK: track_id = evalue;
                    mfc_pkg::CODE_X:     place_finger(1'b1, evalue);
                    mfc_pkg::CODE_Y:     place_finger(1'b0, evalue);
                    default:             ;
                endcase
            end
            return;
        end

        sel_slot = '0;
        track_id = '0;
        if (prefix == PFX_MATCH)
        begin
            cls     = CLASS_NONE;
            present = 1'b0;
        end
        prefix = PFX_START;
        if (cls == reported)
        begin
            return;
        end
        if (cls == CLASS_ONE)
        begin
            word = '{kind: mfc_pkg::KIND_TOUCH, x: last_x, y: last_y};
        end
        else if (cls == CLASS_NONE && reported == CLASS_ONE)
        begin
            word = '{kind: mfc_pkg::KIND_UNTOUCH, x: last_x, y: last_y};
        end
        else
        begin
            word = '{kind: mfc_pkg::KIND_CLEAR, x: 32'sd0, y: 32'sd0};
        end
        reported = cls;
        if (!remote)
        begin
            expected_touches.push_back(word);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        touch_word_t want;
        if (!rst_n)
        begin
            remote   = 1'b0;
            prefix   = PFX_START;
            present  = 1'b0;
            cls      = CLASS_NONE;
            reported = CLASS_NONE;
            primary  = '0;
            sel_slot = '0;
            track_id = '0;
            last_x   = '0;
            last_y   = '0;
            failures = 0;
            expected_touches.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                remote = cfg_data;
            end
            if (touch_valid && !touch_stall)
            begin
                if (expected_touches.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("%0t: unexpected touch word kind=%0d x=%0d y=%0d",
                                 $realtime, touch_kind, touch_x, touch_y);
                    end
                end
                else
                begin
                    want = expected_touches.pop_front();
                    if (touch_kind !== want.kind || touch_x !== want.x || touch_y !== want.y)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display({"%0t: touch word mismatch: expected kind=%0d x=%0d y=%0d,",
                                      " got kind=%0d x=%0d y=%0d"},
                                     $realtime, want.kind, want.x, want.y,
                                     touch_kind, touch_x, touch_y);
                        end
                    end
                end
            end
            if (event_valid && !event_stall)
            begin
                classify_event(event_type, event_code, event_value);
            end
        end
        outstanding = expected_touches.size();
    end

endmodule

FILE: test/tb_multitouch_finger_classifier.sv
`timescale 1ns / 1ps

module tb_multitouch_finger_classifier;

    localparam logic [15:0] EVT_KEY = 16'h0001;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_data = 1'b0;
    logic               event_valid = 1'b0;
    logic               event_stall;
    logic [15:0]        event_type = '0;
    logic [15:0]        event_code = '0;
    logic signed [31:0] event_value = '0;
    logic               touch_valid;
    logic               touch_stall = 1'b0;
    logic [1:0]         touch_kind;
    logic signed [31:0] touch_x;
    logic signed [31:0] touch_y;

    int                 failures;
    int                 outstanding;
    int                 send_idle_pct = 12;
    int                 recv_idle_pct = 45;
    int                 sent_items = 0;
    logic               hold_active = 1'b0;
    event               hold_go;

    multitouch_finger_classifier uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .touch_valid (touch_valid),
        .touch_stall (touch_stall),
        .touch_kind  (touch_kind),
        .touch_x     (touch_x),
        .touch_y     (touch_y)
    );

    touch_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .touch_valid (touch_valid),
        .touch_stall (touch_stall),
        .touch_kind  (touch_kind),
        .touch_x     (touch_x),
        .touch_y     (touch_y),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        touch_stall <= hold_active || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // The receiver refuses every word for a long stretch so that the block backs up.
    initial
    begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (300) @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_event(input logic [15:0] etype, input logic [15:0] ecode,
                              input logic [31:0] evalue);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            event_valid <= 1'b0;
            @(posedge clk);
        end
        event_valid <= 1'b1;
        event_type  <= etype;
        event_code  <= ecode;
        event_value <= evalue;
        @(posedge clk);
        while (event_stall)
        begin
            @(posedge clk);
        end
        sent_items++;
    endtask

    task automatic drain();
        event_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_remote(input logic value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_slot();
        return ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 3);
    endfunction

    task automatic random_frame();
        int          pick;
        logic [15:0] ntype;
        logic [15:0] ncode;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            if ($urandom_range(0, 1))
            begin
                send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_SLOT, pick_slot());
            end
            if ($urandom_range(0, 3) != 0)
            begin
                send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_TRACK,
                           ($urandom_range(0, 4) == 0) ? mfc_pkg::LIFT_ID : $urandom());
            end
            repeat ($urandom_range(1, 3))
            begin
                send_event(mfc_pkg::EVT_ABS,
                           $urandom_range(0, 1) ? mfc_pkg::CODE_X : mfc_pkg::CODE_Y,
                           $urandom());
            end
        end
        else if (pick < 62)
        begin
            if ($urandom_range(0, 1))
            begin
                send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_SLOT,
                           ($urandom_range(0, 4) == 0) ? pick_slot() : 32'd0);
            end
            send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_TRACK, mfc_pkg::LIFT_ID);
            if ($urandom_range(0, 3) == 0)
            begin
                send_event(mfc_pkg::EVT_ABS,
                           $urandom_range(0, 1) ? mfc_pkg::CODE_X : mfc_pkg::CODE_Y,
                           $urandom());
            end
        end
        else if (pick < 80)
        begin
            send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_SLOT, pick_slot());
            send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_X, $urandom());
            send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_SLOT, pick_slot());
            send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_Y, $urandom());
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 3))
                    0:       ntype = 16'($urandom_range(0, 65535));
                    1:       ntype = EVT_KEY;
                    default: ntype = mfc_pkg::EVT_ABS;
                endcase
                case ($urandom_range(0, 5))
                    0:       ncode = mfc_pkg::CODE_SLOT;
                    1:       ncode = mfc_pkg::CODE_TRACK;
                    2:       ncode = mfc_pkg::CODE_X;
                    3:       ncode = mfc_pkg::CODE_Y;
                    default: ncode = 16'($urandom_range(0, 65535));
                endcase
                send_event(ntype, ncode,
                           ($urandom_range(0, 3) == 0) ? mfc_pkg::LIFT_ID : $urandom());
            end
        end
        send_event(mfc_pkg::EVT_SYNC,
                   $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 65535)),
                   $urandom());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 45;
        write_remote(1'b0);

        send_event(mfc_pkg::EVT_SYNC, 16'd0, 32'd0);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_SLOT, 32'd0);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_TRACK, 32'd5);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_X, 32'h7FFF_FFFF);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_Y, 32'h8000_0000);
        send_event(mfc_pkg::EVT_SYNC, 16'd0, 32'd0);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_TRACK, mfc_pkg::LIFT_ID);
        send_event(mfc_pkg::EVT_SYNC, 16'd0, 32'd0);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_SLOT, 32'd0);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_TRACK, 32'd7);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_X, 32'd100);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_SLOT, 32'd3);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_Y, 32'd200);
        send_event(mfc_pkg::EVT_SYNC, 16'd0, 32'd0);
        send_event(EVT_KEY, mfc_pkg::CODE_TRACK, 32'd1);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_TRACK, mfc_pkg::LIFT_ID);
        send_event(mfc_pkg::EVT_SYNC, 16'd0, 32'd0);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_SLOT, 32'd0);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_TRACK, mfc_pkg::LIFT_ID);
        send_event(mfc_pkg::EVT_SYNC, 16'd0, 32'd0);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_SLOT, 32'd2);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_TRACK, mfc_pkg::LIFT_ID);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_X, 32'd5);
        send_event(mfc_pkg::EVT_SYNC, 16'hFFFF, 32'hFFFF_FFFF);
        send_event(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_event(mfc_pkg::EVT_ABS, 16'hFFFF, 32'd0);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_SLOT, 32'hFFFF_FFFF);
        send_event(mfc_pkg::EVT_ABS, mfc_pkg::CODE_X, 32'd1);
        send_event(mfc_pkg::EVT_SYNC, 16'd0, 32'd0);

        while (sent_items < 220)
        begin
            random_frame();
        end
        -> hold_go;
        while (sent_items < 450)
        begin
            random_frame();
        end
        drain();

        send_idle_pct = 45;
        recv_idle_pct = 12;
        write_remote(1'b1);
        while (sent_items < 650)
        begin
            random_frame();
        end
        drain();
        write_remote(1'b0);
        while (sent_items < 950)
        begin
            random_frame();
        end
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent_items < 1200)
        begin
            random_frame();
        end
        drain();
        while (sent_items < 1450)
        begin
            random_frame();
        end
        drain();

        if (failures == 0 && outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
